// ===== rtl/core/ilir_pkg.sv =====
// Indexed list package: default sizes, request and status codes, cell command
// and controller state types. No dependencies.
package ilir_pkg;

   localparam int CAPACITY_DEF  = 256;
   localparam int ITEM_BITS_DEF = 32;
   localparam int POS_BITS_DEF  = $clog2(CAPACITY_DEF + 1);
   localparam int REQ_BITS      = 3;
   localparam int STATUS_BITS   = 2;
   localparam int GATHER_GROUP  = 16;

   localparam logic [REQ_BITS-1:0] OP_GET    = 3'd0;
   localparam logic [REQ_BITS-1:0] OP_SET    = 3'd1;
   localparam logic [REQ_BITS-1:0] OP_INSERT = 3'd2;
   localparam logic [REQ_BITS-1:0] OP_REMOVE = 3'd3;
   localparam logic [REQ_BITS-1:0] OP_CLEAR  = 3'd4;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_APPLY = 1'b1
   } state_type;

   typedef struct packed {
      logic ins;
      logic rem;
      logic wr;
   } cell_cmd_type;

endpackage

// ===== rtl/core/ilir_if.sv =====
// Valid/ready channel interfaces for the indexed list: request and response.
// Depends on ilir_pkg.
interface ilir_req_if #(
   parameter int POS_BITS  = ilir_pkg::POS_BITS_DEF,
   parameter int ITEM_BITS = ilir_pkg::ITEM_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [ilir_pkg::REQ_BITS-1:0] req_type;
   logic [POS_BITS-1:0]           position;
   logic [ITEM_BITS-1:0]          item_value;

   modport source (output valid, req_type, position, item_value, input ready);
   modport sink (input valid, req_type, position, item_value, output ready);
   modport monitor (input valid, ready, req_type, position, item_value);
endinterface

interface ilir_rsp_if #(
   parameter int POS_BITS  = ilir_pkg::POS_BITS_DEF,
   parameter int ITEM_BITS = ilir_pkg::ITEM_BITS_DEF
);
   logic                             valid;
   logic                             ready;
   logic [ilir_pkg::STATUS_BITS-1:0] status;
   logic [ITEM_BITS-1:0]             read_item;
   logic [POS_BITS-1:0]              item_count;

   modport source (output valid, status, read_item, item_count, input ready);
   modport sink (input valid, status, read_item, item_count, output ready);
   modport monitor (input valid, ready, status, read_item, item_count);
endinterface

// ===== rtl/core/indexed_list_insert_remove.sv =====
// Indexed list with insert/remove: controller, row of ilir_cell and the
// ilir_gather read unit. Depends on ilir_pkg, ilir_if, ilir_cell, ilir_gather.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        req_type, position, item_value
//   rsp_chan  out  valid/ready        status, read_item, item_count
//
// The transfer cycle registers the per-group read selection; the apply state
// finishes the read, updates the count and shifts the whole cell row at once.
// One request is in flight at a time.
// A response waiting on rsp_chan.ready holds the apply state back.
// Reset clears the count, the controller and the response valid; cell
// contents are left as they are.
module indexed_list_insert_remove #(
   parameter int CAPACITY  = ilir_pkg::CAPACITY_DEF,
   parameter int ITEM_BITS = ilir_pkg::ITEM_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   ilir_req_if.sink     req_chan,
   ilir_rsp_if.source   rsp_chan
);

   localparam int POS_BITS = $clog2(CAPACITY + 1);
   localparam logic [POS_BITS-1:0] FULL_COUNT = POS_BITS'(CAPACITY);

   ilir_pkg::state_type           state_ff, state_in;
   logic [ilir_pkg::REQ_BITS-1:0] op_ff, op_in;
   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic [ITEM_BITS-1:0]          val_ff, val_in;
   logic [POS_BITS-1:0]           count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ilir_pkg::status_type          status_ff, status_in;
   logic [ITEM_BITS-1:0]          read_ff, read_in;

   ilir_pkg::status_type   status_c;
   logic [ITEM_BITS-1:0]   read_c;
   logic [POS_BITS-1:0]    count_c;
   ilir_pkg::cell_cmd_type cmd_c;
   ilir_pkg::cell_cmd_type cell_cmd;

   logic                 req_xfer;
   logic                 rsp_xfer;
   logic                 apply_go;
   logic                 below;
   logic                 at_end;
   logic                 full;
   logic [ITEM_BITS-1:0] gathered;

   logic [ITEM_BITS-1:0] items [CAPACITY];
   logic [ITEM_BITS-1:0] left_w [CAPACITY];
   logic [ITEM_BITS-1:0] right_w [CAPACITY];

   assign req_chan.ready = (state_ff == ilir_pkg::S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_valid_ff && rsp_chan.ready;
   assign apply_go       = (state_ff == ilir_pkg::S_APPLY) && (!rsp_valid_ff || rsp_chan.ready);

   assign below  = pos_ff < count_ff;
   assign at_end = pos_ff == count_ff;
   assign full   = count_ff == FULL_COUNT;

   always_comb begin
      status_c = ilir_pkg::ST_OK;
      read_c   = '0;
      count_c  = count_ff;
      cmd_c    = '0;
      unique case (op_ff)
         ilir_pkg::OP_GET: begin
            if (!below) begin
               status_c = ilir_pkg::ST_RANGE;
            end else begin
               read_c = gathered;
            end
         end
         ilir_pkg::OP_SET: begin
            if (!below && !at_end) begin
               status_c = ilir_pkg::ST_RANGE;
            end else if (at_end) begin
               if (full) begin
                  status_c = ilir_pkg::ST_FULL;
               end else begin
                  cmd_c.wr = 1'b1;
                  count_c  = count_ff + POS_BITS'(1);
               end
            end else begin
               cmd_c.wr = 1'b1;
            end
         end
         ilir_pkg::OP_INSERT: begin
            if (!below && !at_end) begin
               status_c = ilir_pkg::ST_RANGE;
            end else if (full) begin
               status_c = ilir_pkg::ST_FULL;
            end else begin
               cmd_c.ins = 1'b1;
               count_c   = count_ff + POS_BITS'(1);
            end
         end
         ilir_pkg::OP_REMOVE: begin
            if (!below) begin
               status_c = ilir_pkg::ST_RANGE;
            end else begin
               cmd_c.rem = 1'b1;
               read_c    = gathered;
               count_c   = count_ff - POS_BITS'(1);
            end
         end
         ilir_pkg::OP_CLEAR: begin
            count_c = '0;
         end
         default: begin
         end
      endcase
   end

   assign cell_cmd = apply_go ? cmd_c : '0;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      read_in      = read_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ilir_pkg::S_IDLE: begin
            if (req_xfer) begin
               state_in = ilir_pkg::S_APPLY;
               op_in    = req_chan.req_type;
               pos_in   = req_chan.position;
               val_in   = req_chan.item_value;
            end
         end
         ilir_pkg::S_APPLY: begin
            if (apply_go) begin
               state_in     = ilir_pkg::S_IDLE;
               count_in     = count_c;
               rsp_valid_in = 1'b1;
               status_in    = status_c;
               read_in      = read_c;
            end
         end
         default: begin
            state_in = ilir_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilir_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      read_ff   <= read_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_w[i] = '0;
      end else begin : g_left
         assign left_w[i] = items[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w[i] = '0;
      end else begin : g_right
         assign right_w[i] = items[i+1];
      end

      ilir_cell #(
         .ITEM_BITS  (ITEM_BITS),
         .POS_BITS   (POS_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .position   (pos_ff),
         .item_value (val_ff),
         .left_item  (left_w[i]),
         .right_item (right_w[i]),
         .item       (items[i])
      );
   end

   ilir_gather #(
      .CAPACITY  (CAPACITY),
      .ITEM_BITS (ITEM_BITS),
      .POS_BITS  (POS_BITS)
   ) u_gather (
      .clock     (clock),
      .load      (req_xfer),
      .position  (req_chan.position),
      .items     (items),
      .read_item (gathered)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.read_item  = read_ff;
   assign rsp_chan.item_count = count_ff;

endmodule

// ===== rtl/core/ilir_cell.sv =====
// One storage cell of the list row: holds one item and takes the neighbour's
// item on insert/remove shifts. Depends on ilir_pkg.
module ilir_cell #(
   parameter int ITEM_BITS  = ilir_pkg::ITEM_BITS_DEF,
   parameter int POS_BITS   = ilir_pkg::POS_BITS_DEF,
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  ilir_pkg::cell_cmd_type cmd,
   input  logic [POS_BITS-1:0]    position,
   input  logic [ITEM_BITS-1:0]   item_value,
   input  logic [ITEM_BITS-1:0]   left_item,
   input  logic [ITEM_BITS-1:0]   right_item,
   output logic [ITEM_BITS-1:0]   item
);

   localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(CELL_INDEX);

   logic [ITEM_BITS-1:0] item_ff;
   logic [ITEM_BITS-1:0] item_in;

   always_comb begin
      item_in = item_ff;
      if (cmd.ins && (MY_POS > position)) begin
         item_in = left_item;
      end else if ((cmd.ins || cmd.wr) && (MY_POS == position)) begin
         item_in = item_value;
      end else if (cmd.rem && (MY_POS >= position)) begin
         item_in = right_item;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item = item_ff;

endmodule

// ===== rtl/core/ilir_gather.sv =====
// Read gather for the cell row: position-masked items ORed per group and
// registered, then ORed across groups. Depends on ilir_pkg.
module ilir_gather #(
   parameter int CAPACITY  = ilir_pkg::CAPACITY_DEF,
   parameter int ITEM_BITS = ilir_pkg::ITEM_BITS_DEF,
   parameter int POS_BITS  = ilir_pkg::POS_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic [POS_BITS-1:0]  position,
   input  logic [ITEM_BITS-1:0] items [CAPACITY],
   output logic [ITEM_BITS-1:0] read_item
);

   localparam int GROUP   = ilir_pkg::GATHER_GROUP;
   localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;
   localparam int PADDED  = NGROUPS * GROUP;

   logic [ITEM_BITS-1:0] masked [PADDED];
   logic [ITEM_BITS-1:0] group_in [NGROUPS];
   logic [ITEM_BITS-1:0] group_ff [NGROUPS];

   for (genvar i = 0; i < PADDED; i++) begin : g_mask
      if (i < CAPACITY) begin : g_real
         assign masked[i] = (position == POS_BITS'(i)) ? items[i] : '0;
      end else begin : g_pad
         assign masked[i] = '0;
      end
   end

   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP; j++) begin
            group_in[g] = group_in[g] | masked[g * GROUP + j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         group_ff <= group_in;
      end
   end

   always_comb begin
      read_item = '0;
      for (int g = 0; g < NGROUPS; g++) begin
         read_item = read_item | group_ff[g];
      end
   end

endmodule

// ===== rtl/core/ilir_checker.sv =====
// Port-level checks for indexed_list_insert_remove, bound to the top level.
// Depends on ilir_pkg.
module ilir_checker #(
   parameter int CAPACITY  = ilir_pkg::CAPACITY_DEF,
   parameter int ITEM_BITS = ilir_pkg::ITEM_BITS_DEF,
   parameter int POS_BITS  = $clog2(CAPACITY + 1)
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ilir_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [ITEM_BITS-1:0]             rsp_read_item,
   input logic [POS_BITS-1:0]              rsp_item_count
);

   // response held until transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_read_item) && $stable(rsp_status))
      else $error("response changed before transfer");

   // one request in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ilir_pkg::ST_FULL) |->
         rsp_item_count == POS_BITS'(CAPACITY))
      else $error("full status without full count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ilir_pkg::ST_OK) |-> rsp_read_item == '0)
      else $error("error response carries data");

endmodule

bind indexed_list_insert_remove ilir_checker #(
   .CAPACITY  (CAPACITY),
   .ITEM_BITS (ITEM_BITS)
) u_ilir_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_read_item  (rsp_chan.read_item),
   .rsp_item_count (rsp_chan.item_count)
);
